// ===== sv/datetime_difference_seconds_defines.svh =====
// ----------------------------------------------------------------------------
// datetime_difference_seconds_defines
// Assertion macros used by the datetime difference top module.
// ----------------------------------------------------------------------------
`ifndef DATETIME_DIFFERENCE_SECONDS_DEFINES_SVH
`define DATETIME_DIFFERENCE_SECONDS_DEFINES_SVH

// antecedent now, consequent a fixed number of cycles later
`define DTDS_ASSERT_DELAY(lbl, clk, rst, ante, dly, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
      else $error("dtds: delayed check failed");

// antecedent and consequent in the same cycle
`define DTDS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtds: same-cycle check failed");

`endif

// ===== sv/dtds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtds_pkg
// Widths, constants and the month table for the datetime difference block.
// ----------------------------------------------------------------------------
package dtds_pkg;

   localparam int unsigned DTDS_MAX_YEAR = 9999;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int SECS_W  = 39;

   localparam int DAYS_W  = 23;
   localparam int SOD_W   = 17;
   localparam int DBM_W   = 9;
   localparam int CENT_W  = 8;

   // floor(y / 100) = (y * 5243) >> 19, exact for 14-bit y
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = RECIP_SHIFT + CENT_W;

   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int DAYS_PER_YEAR = 365;

   localparam int STAMP_STAGES = 4;
   localparam int PIPE_DEPTH   = STAMP_STAGES + 1;

   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

   function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] mo);
      logic [DBM_W-1:0] d;
      case (mo)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd365;
      endcase
      return d;
   endfunction

endpackage

// ===== sv/datetime_difference_seconds.sv =====
// rsp_valid strobes for each request taken with start, once it has passed the pipeline.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Depth is set by the four-stage stamp conversion plus the difference register.
// Reset (synchronous) drops every request in flight; no result follows it.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// datetime_difference_seconds
// Absolute difference in seconds between two Gregorian timestamps.
// ----------------------------------------------------------------------------
`include "datetime_difference_seconds_defines.svh"

module datetime_difference_seconds import dtds_pkg::*; #(
   parameter int unsigned MAX_YEAR = DTDS_MAX_YEAR
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [YEAR_W-1:0]  req_first_year,
   input  logic [MONTH_W-1:0] req_first_month,
   input  logic [DAY_W-1:0]   req_first_day,
   input  logic [HOUR_W-1:0]  req_first_hour,
   input  logic [MIN_W-1:0]   req_first_minute,
   input  logic [SEC_W-1:0]   req_first_second,
   input  logic [YEAR_W-1:0]  req_second_year,
   input  logic [MONTH_W-1:0] req_second_month,
   input  logic [DAY_W-1:0]   req_second_day,
   input  logic [HOUR_W-1:0]  req_second_hour,
   input  logic [MIN_W-1:0]   req_second_minute,
   input  logic [SEC_W-1:0]   req_second_sec,
   output logic               rsp_valid,
   output logic [SECS_W-1:0]  rsp_elapsed_seconds
);

   logic [SECS_W-1:0]     secs_a, secs_b;
   logic [PIPE_DEPTH-1:0] valid_in, valid_ff;

   assign busy = 1'b0;

   dtds_stamp #(
      .MAX_YEAR (MAX_YEAR)
   ) u_stamp_a (
      .clock  (clock),
      .year   (req_first_year),
      .month  (req_first_month),
      .day    (req_first_day),
      .hour   (req_first_hour),
      .minute (req_first_minute),
      .sec    (req_first_second),
      .secs   (secs_a)
   );

   dtds_stamp #(
      .MAX_YEAR (MAX_YEAR)
   ) u_stamp_b (
      .clock  (clock),
      .year   (req_second_year),
      .month  (req_second_month),
      .day    (req_second_day),
      .hour   (req_second_hour),
      .minute (req_second_minute),
      .sec    (req_second_sec),
      .secs   (secs_b)
   );

   dtds_absdiff u_absdiff (
      .clock  (clock),
      .secs_a (secs_a),
      .secs_b (secs_b),
      .diff   (rsp_elapsed_seconds)
   );

   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff[PIPE_DEPTH-1];

   `DTDS_ASSERT_DELAY(a_req_gives_rsp, clock, reset, start, PIPE_DEPTH, rsp_valid)
   `DTDS_ASSERT_NOW(a_rsp_has_req, clock, reset, rsp_valid, $past(start, PIPE_DEPTH))
   `DTDS_ASSERT_DELAY(a_same_stamp_zero, clock, reset, start && (req_first_year == req_second_year) && (req_first_month == req_second_month) && (req_first_day == req_second_day) && (req_first_hour == req_second_hour) && (req_first_minute == req_second_minute) && (req_first_second == req_second_sec), PIPE_DEPTH, rsp_elapsed_seconds == '0)

endmodule

// ===== sv/dtds_stamp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtds_stamp
// Four-stage conversion of one timestamp to a linear second count from year 0 (day numbers start at 1).
// ----------------------------------------------------------------------------
module dtds_stamp import dtds_pkg::*; #(
   parameter int unsigned MAX_YEAR = DTDS_MAX_YEAR
) (
   input  logic                clock,
   input  logic [YEAR_W-1:0]   year,
   input  logic [MONTH_W-1:0]  month,
   input  logic [DAY_W-1:0]    day,
   input  logic [HOUR_W-1:0]   hour,
   input  logic [MIN_W-1:0]    minute,
   input  logic [SEC_W-1:0]    sec,
   output logic [SECS_W-1:0]   secs
);

   // stage 1: saturate year, century product, seconds of day
   logic [YEAR_W-1:0]  y1_in, y1_ff;
   logic [PROD_W-1:0]  prod1_in, prod1_ff;
   logic [SOD_W-1:0]   sod1_in, sod1_ff;
   logic [MONTH_W-1:0] mo1_ff;
   logic [DAY_W-1:0]   d1_ff;

   always_comb begin
      if (32'(year) > MAX_YEAR) begin
         y1_in = YEAR_W'(MAX_YEAR);
      end else begin
         y1_in = year;
      end
      prod1_in = PROD_W'(y1_in) * PROD_W'(RECIP_100);
      sod1_in  = SOD_W'(hour) * SOD_W'(SECS_PER_HOUR) + SOD_W'(minute) * SOD_W'(SECS_PER_MIN)
               + SOD_W'(sec);
   end

   always_ff @(posedge clock) begin
      y1_ff    <= y1_in;
      prod1_ff <= prod1_in;
      sod1_ff  <= sod1_in;
      mo1_ff   <= month;
      d1_ff    <= day;
   end

   // stage 2: century quotient and remainder check
   logic [CENT_W-1:0]  qy2_in, qy2_ff;
   logic               rz2_in, rz2_ff;
   logic [YEAR_W-1:0]  y2_ff;
   logic [SOD_W-1:0]   sod2_ff;
   logic [MONTH_W-1:0] mo2_ff;
   logic [DAY_W-1:0]   d2_ff;

   always_comb begin
      qy2_in = prod1_ff[RECIP_SHIFT +: CENT_W];
      rz2_in = ((y1_ff - YEAR_W'(qy2_in) * YEAR_W'(100)) == '0);
   end

   always_ff @(posedge clock) begin
      qy2_ff  <= qy2_in;
      rz2_ff  <= rz2_in;
      y2_ff   <= y1_ff;
      sod2_ff <= sod1_ff;
      mo2_ff  <= mo1_ff;
      d2_ff   <= d1_ff;
   end

   // stage 3: day count
   logic [DAYS_W-1:0] days3_in, days3_ff;
   logic [SOD_W-1:0]  sod3_ff;
   logic [YEAR_W-1:0] p3;
   logic [CENT_W-1:0] q100p3;
   logic              leap3;
   logic [DAYS_W-1:0] dby3;

   always_comb begin
      p3     = y2_ff - YEAR_W'(1);
      leap3  = rz2_ff ? (qy2_ff[1:0] == 2'd0) : (y2_ff[1:0] == 2'd0);
      q100p3 = (rz2_ff && (y2_ff != '0)) ? (qy2_ff - CENT_W'(1)) : qy2_ff;
      if (y2_ff == '0) begin
         dby3 = '0;
      end else begin
         dby3 = DAYS_W'(y2_ff) * DAYS_W'(DAYS_PER_YEAR) + DAYS_W'(p3 >> 2)
              - DAYS_W'(q100p3) + DAYS_W'(q100p3 >> 2) + DAYS_W'(1);
      end
      days3_in = dby3 + DAYS_W'(days_before_month(mo2_ff)) + DAYS_W'(d2_ff)
               + DAYS_W'((mo2_ff > MONTH_FEB) && leap3);
   end

   always_ff @(posedge clock) begin
      days3_ff <= days3_in;
      sod3_ff  <= sod2_ff;
   end

   // stage 4: linear seconds
   logic [SECS_W-1:0] secs4_in, secs4_ff;

   assign secs4_in = SECS_W'(days3_ff) * SECS_W'(SECS_PER_DAY) + SECS_W'(sod3_ff);

   always_ff @(posedge clock) begin
      secs4_ff <= secs4_in;
   end

   assign secs = secs4_ff;

endmodule

// ===== sv/dtds_absdiff.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtds_absdiff
// Registered absolute difference of two second counts.
// ----------------------------------------------------------------------------
module dtds_absdiff import dtds_pkg::*; (
   input  logic              clock,
   input  logic [SECS_W-1:0] secs_a,
   input  logic [SECS_W-1:0] secs_b,
   output logic [SECS_W-1:0] diff
);

   logic [SECS_W-1:0] diff_in, diff_ff;

   assign diff_in = (secs_a >= secs_b) ? (secs_a - secs_b) : (secs_b - secs_a);

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
   end

   assign diff = diff_ff;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the datetime difference block: timestamp pairs go
// in from a queue, each elapsed time is predicted in-bench and matched
// in order against the result strobes.
// ----------------------------------------------------------------------------
module tb_top;
   import dtds_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_COUNT   = 880;

   localparam int unsigned MONTH_START [16] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243,
                                                273, 304, 334, 365, 365, 365};
   localparam int unsigned MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31,
                                               30, 31};

   typedef struct {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MIN_W-1:0]   minute;
      logic [SEC_W-1:0]   sec;
   } stamp_type;

   typedef struct {
      stamp_type first;
      stamp_type second;
   } stamp_pair_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [YEAR_W-1:0]  req_first_year    = '0;
   logic [MONTH_W-1:0] req_first_month   = '0;
   logic [DAY_W-1:0]   req_first_day     = '0;
   logic [HOUR_W-1:0]  req_first_hour    = '0;
   logic [MIN_W-1:0]   req_first_minute  = '0;
   logic [SEC_W-1:0]   req_first_second  = '0;
   logic [YEAR_W-1:0]  req_second_year   = '0;
   logic [MONTH_W-1:0] req_second_month  = '0;
   logic [DAY_W-1:0]   req_second_day    = '0;
   logic [HOUR_W-1:0]  req_second_hour   = '0;
   logic [MIN_W-1:0]   req_second_minute = '0;
   logic [SEC_W-1:0]   req_second_sec    = '0;
   logic               rsp_valid;
   logic [SECS_W-1:0]  rsp_elapsed_seconds;

   stamp_pair_type    pending_pairs [$];
   logic [SECS_W-1:0] elapsed_due [$];
   stamp_pair_type    on_ports;
   int                total_pairs = 0;
   int                directed_pairs = 0;
   int                sent_pairs = 0;
   int                checked = 0;
   int                fail_count = 0;
   int                quiet_cycles = 0;

   datetime_difference_seconds i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_first_year      (req_first_year),
      .req_first_month     (req_first_month),
      .req_first_day       (req_first_day),
      .req_first_hour      (req_first_hour),
      .req_first_minute    (req_first_minute),
      .req_first_second    (req_first_second),
      .req_second_year     (req_second_year),
      .req_second_month    (req_second_month),
      .req_second_day      (req_second_day),
      .req_second_hour     (req_second_hour),
      .req_second_minute   (req_second_minute),
      .req_second_sec      (req_second_sec),
      .rsp_valid           (rsp_valid),
      .rsp_elapsed_seconds (rsp_elapsed_seconds)
   );

   always #5 clock = ~clock;

   function automatic bit is_leap(longint unsigned yr);
      return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
   endfunction

   function automatic longint unsigned stamp_to_secs(stamp_type s);
      longint unsigned yr;
      longint unsigned prior;
      longint unsigned days;
      yr = 64'(s.year);
      if (yr > DTDS_MAX_YEAR) begin
         yr = 64'(DTDS_MAX_YEAR);
      end
      if (yr == 0) begin
         days = 0;
      end else begin
         prior = yr - 1;
         days = DAYS_PER_YEAR * yr + prior / 4 - prior / 100 + prior / 400 + 1;
      end
      days += MONTH_START[s.month] + s.day;
      if (s.month > MONTH_FEB && is_leap(yr)) begin
         days += 1;
      end
      return days * SECS_PER_DAY + s.hour * SECS_PER_HOUR + s.minute * SECS_PER_MIN + s.sec;
   endfunction

   function automatic logic [SECS_W-1:0] elapsed_between(stamp_pair_type p);
      longint unsigned a;
      longint unsigned b;
      longint unsigned diff;
      a = stamp_to_secs(p.first);
      b = stamp_to_secs(p.second);
      diff = (a >= b) ? a - b : b - a;
      return diff[SECS_W-1:0];
   endfunction

   function automatic int unsigned month_length(int unsigned yr, int unsigned mo);
      if (mo == MONTH_FEB && is_leap(yr)) begin
         return 29;
      end
      return MONTH_DAYS[mo];
   endfunction

   function automatic stamp_type mk(int unsigned y, int unsigned mo, int unsigned d,
                                    int unsigned h, int unsigned mi, int unsigned s);
      stamp_type t;
      t.year   = YEAR_W'(y);
      t.month  = MONTH_W'(mo);
      t.day    = DAY_W'(d);
      t.hour   = HOUR_W'(h);
      t.minute = MIN_W'(mi);
      t.sec    = SEC_W'(s);
      return t;
   endfunction

   function automatic stamp_type random_date();
      stamp_type t;
      t.year = YEAR_W'($urandom_range(1, DTDS_MAX_YEAR));
      // century and leap boundaries get extra weight
      if ($urandom_range(0, 3) == 0) begin
         t.year = YEAR_W'(100 * $urandom_range(1, 99) + $urandom_range(0, 4));
      end
      t.month  = MONTH_W'($urandom_range(1, 12));
      t.day    = DAY_W'($urandom_range(1, month_length(32'(t.year), 32'(t.month))));
      t.hour   = HOUR_W'($urandom_range(0, 23));
      t.minute = MIN_W'($urandom_range(0, 59));
      t.sec    = SEC_W'($urandom_range(0, 59));
      return t;
   endfunction

   function automatic stamp_type random_bits();
      stamp_type t;
      t.year   = YEAR_W'($urandom_range(0, 2**YEAR_W - 1));
      t.month  = MONTH_W'($urandom_range(0, 2**MONTH_W - 1));
      t.day    = DAY_W'($urandom_range(0, 2**DAY_W - 1));
      t.hour   = HOUR_W'($urandom_range(0, 2**HOUR_W - 1));
      t.minute = MIN_W'($urandom_range(0, 2**MIN_W - 1));
      t.sec    = SEC_W'($urandom_range(0, 2**SEC_W - 1));
      return t;
   endfunction

   // same year, some lower fields moved, to exercise the borrow chain
   function automatic stamp_type nearby(stamp_type s);
      stamp_type t;
      t = s;
      case ($urandom_range(0, 4))
         0: begin
            t.sec = SEC_W'($urandom_range(0, 59));
         end
         1: begin
            t.minute = MIN_W'($urandom_range(0, 59));
            t.sec    = SEC_W'($urandom_range(0, 59));
         end
         2: begin
            t.hour   = HOUR_W'($urandom_range(0, 23));
            t.minute = MIN_W'($urandom_range(0, 59));
         end
         3: begin
            t.day  = DAY_W'($urandom_range(1, month_length(32'(t.year), 32'(t.month))));
            t.hour = HOUR_W'($urandom_range(0, 23));
         end
         default: begin
            t.month = MONTH_W'($urandom_range(1, 12));
            t.day   = DAY_W'($urandom_range(1, month_length(32'(t.year), 32'(t.month))));
         end
      endcase
      return t;
   endfunction

   task automatic queue_pair(stamp_type a, stamp_type b);
      stamp_pair_type p;
      p.first  = a;
      p.second = b;
      pending_pairs.push_back(p);
   endtask

   initial begin
      stamp_type a;
      stamp_type b;
      queue_pair(mk(2000, 1, 1, 0, 0, 0), mk(2000, 1, 1, 0, 0, 0));
      queue_pair(mk(1, 1, 1, 0, 0, 0), mk(9999, 12, 31, 23, 59, 59));
      queue_pair(mk(9999, 12, 31, 23, 59, 59), mk(1, 1, 1, 0, 0, 0));
      queue_pair(mk(2000, 2, 28, 23, 59, 59), mk(2000, 3, 1, 0, 0, 0));
      queue_pair(mk(1900, 3, 1, 0, 0, 0), mk(1900, 2, 28, 23, 59, 59));
      queue_pair(mk(2004, 12, 31, 23, 59, 59), mk(2005, 1, 1, 0, 0, 0));
      queue_pair(mk(2023, 3, 1, 0, 0, 0), mk(2023, 2, 28, 23, 59, 59));
      queue_pair(mk(2024, 2, 29, 12, 30, 30), mk(2024, 3, 1, 12, 30, 31));
      queue_pair(mk(0, 1, 1, 0, 0, 0), mk(1, 1, 1, 0, 0, 0));
      queue_pair(mk(0, 3, 1, 0, 0, 0), mk(0, 2, 28, 0, 0, 0));
      queue_pair(mk(10000, 6, 15, 8, 0, 0), mk(9999, 6, 15, 8, 0, 0));
      queue_pair(mk(16383, 1, 1, 0, 0, 0), mk(1, 1, 1, 0, 0, 0));
      queue_pair(mk(2021, 0, 5, 0, 0, 0), mk(2021, 1, 5, 0, 0, 0));
      queue_pair(mk(2021, 13, 1, 0, 0, 0), mk(2021, 12, 1, 0, 0, 0));
      queue_pair(mk(2020, 15, 31, 0, 0, 0), mk(2021, 1, 1, 0, 0, 0));
      queue_pair(mk(1999, 6, 0, 31, 63, 63), mk(1999, 6, 1, 0, 0, 0));
      queue_pair(mk(16383, 15, 31, 31, 63, 63), mk(0, 0, 0, 0, 0, 0));
      queue_pair(mk(0, 0, 0, 0, 0, 0), mk(0, 0, 0, 0, 0, 0));
      queue_pair(mk(1970, 1, 1, 0, 0, 59), mk(1970, 1, 1, 0, 0, 0));
      queue_pair(mk(1970, 1, 1, 0, 0, 0), mk(1969, 12, 31, 23, 59, 59));
      queue_pair(mk(2100, 3, 1, 0, 0, 0), mk(2100, 2, 28, 0, 0, 0));
      queue_pair(mk(2400, 3, 1, 0, 0, 0), mk(2400, 2, 28, 0, 0, 0));
      directed_pairs = pending_pairs.size();

      repeat (RANDOM_COUNT) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               a = random_date();
               b = random_date();
            end
            4, 5, 6: begin
               a = random_date();
               b = nearby(a);
            end
            7: begin
               a = random_date();
               b = random_bits();
            end
            default: begin
               a = random_bits();
               b = random_bits();
            end
         endcase
         if ($urandom_range(0, 1) == 1) begin
            queue_pair(b, a);
         end else begin
            queue_pair(a, b);
         end
      end
      total_pairs = pending_pairs.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (pending_pairs.size() != 0 || start);
      do @(posedge clock);
      while (elapsed_due.size() != 0);
      repeat (PIPE_DEPTH + 4) @(posedge clock);

      $display("Sent %0d timestamp pairs (%0d directed, the rest random dates and raw bits).",
               sent_pairs, directed_pairs);
      $display("Checked %0d elapsed times, %0d mismatches.", checked, fail_count);
      if (fail_count == 0) begin
         $display("datetime_difference_seconds test passed");
      end else begin
         $display("datetime_difference_seconds test failed");
      end
      $finish;
   end

   function automatic int unsigned sender_idle_pct();
      if (sent_pairs < total_pairs / 3) begin
         return 12;
      end else if (sent_pairs < 2 * total_pairs / 3) begin
         return 48;
      end
      return 0;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            elapsed_due.push_back(elapsed_between(on_ports));
            sent_pairs++;
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_pairs.size() != 0 &&
                      $urandom_range(0, 99) >= sender_idle_pct()) begin
            on_ports = pending_pairs.pop_front();
            req_first_year    <= on_ports.first.year;
            req_first_month   <= on_ports.first.month;
            req_first_day     <= on_ports.first.day;
            req_first_hour    <= on_ports.first.hour;
            req_first_minute  <= on_ports.first.minute;
            req_first_second  <= on_ports.first.sec;
            req_second_year   <= on_ports.second.year;
            req_second_month  <= on_ports.second.month;
            req_second_day    <= on_ports.second.day;
            req_second_hour   <= on_ports.second.hour;
            req_second_minute <= on_ports.second.minute;
            req_second_sec    <= on_ports.second.sec;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      logic [SECS_W-1:0] want;
      if (!reset) begin
         if (rsp_valid) begin
            if (elapsed_due.size() == 0) begin
               $error("unexpected result: elapsed_seconds %0d", rsp_elapsed_seconds);
               fail_count++;
            end else begin
               want = elapsed_due.pop_front();
               checked++;
               if (rsp_elapsed_seconds !== want) begin
                  $error("elapsed_seconds mismatch: expected %0d, actual %0d",
                         want, rsp_elapsed_seconds);
                  fail_count++;
               end
            end
         end
         if (rsp_valid || (start && !busy)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no request or result for %0d cycles.", WATCHDOG_LIMIT);
            $display("datetime_difference_seconds test failed");
            $finish;
         end
      end
   end

endmodule

// ===== datetime_difference_seconds.f =====
+incdir+sv
sv/dtds_pkg.sv
sv/dtds_stamp.sv
sv/dtds_absdiff.sv
sv/datetime_difference_seconds.sv
verif/tb_top.sv
